// ===== sv/alle_pkg.sv =====
// Shared types and constants for the array linked list engine.
package alle_pkg;

    localparam logic [2:0] CMD_ADD_FIRST = 3'd0;
    localparam logic [2:0] CMD_ADD_AFTER = 3'd1;
    localparam logic [2:0] CMD_ADD_LAST  = 3'd2;
    localparam logic [2:0] CMD_DEL_FIRST = 3'd3;
    localparam logic [2:0] CMD_DEL_AFTER = 3'd4;
    localparam logic [2:0] CMD_DEL_LAST  = 3'd5;
    localparam logic [2:0] CMD_DEL_ALL   = 3'd6;
    localparam logic [2:0] CMD_LIST_ALL  = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    localparam int CMD_W = 3;
    localparam int POS_W = 3;
    localparam int CNT_W = 4;
    localparam int STAT_W = 2;
    localparam int DATA_W = 64;

    // datapath operations requested by the controller
    localparam logic [3:0] OP_NONE       = 4'd0;
    localparam logic [3:0] OP_LOAD       = 4'd1;
    localparam logic [3:0] OP_FREE_STEP  = 4'd2;
    localparam logic [3:0] OP_WALK_INIT  = 4'd3;
    localparam logic [3:0] OP_WALK_STEP  = 4'd4;
    localparam logic [3:0] OP_INS_HEAD   = 4'd5;
    localparam logic [3:0] OP_INS_AFTER  = 4'd6;
    localparam logic [3:0] OP_INS_TAIL   = 4'd7;
    localparam logic [3:0] OP_DEL_HEAD   = 4'd8;
    localparam logic [3:0] OP_DEL_AFTER  = 4'd9;
    localparam logic [3:0] OP_DEL_LAST   = 4'd10;
    localparam logic [3:0] OP_CLEAR      = 4'd11;
    localparam logic [3:0] OP_EMIT_REJ   = 4'd12;
    localparam logic [3:0] OP_LIST_STEP  = 4'd13;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] rej_status;
    } alle_cmd_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       full;
        logic       empty;
        logic       pos_ok;
        logic       pos_has_next;
        logic       free_found;
        logic       walk_done;
        logic       head_single;
        logic       list_last;
    } alle_stat_t;

endpackage

// ===== sv/array_linked_list_engine_core.sv =====
// Top level of the array linked list engine: controller plus datapath.
// Adds scan for a free slot; add_last then walks to the tail, one step a cycle.
// list_all gives its words one a cycle.
// Throughput: one command at a time; busy falls in the cycle the final word is out.
// Reset: asynchronous, active low; list empty, all slots free, count zero. No receiver stall.
module array_linked_list_engine_core
#(
    parameter int SLOT_COUNT = 8,
    parameter int TEXT_BITS  = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [2:0]  position,
    input  logic [63:0] name_text,
    input  logic [63:0] level_text,
    input  logic [63:0] game_text,
    output logic        strobe,
    output logic [1:0]  status,
    output logic [3:0]  entry_count,
    output logic [2:0]  slot,
    output logic [63:0] out_name,
    output logic [63:0] out_level,
    output logic [63:0] out_game,
    output logic        last_of_run
);

    alle_pkg::alle_cmd_t  cmd;
    alle_pkg::alle_stat_t st;

    alle_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .st    (st),
        .cmd   (cmd)
    );

    alle_dp #(
        .SLOT_COUNT (SLOT_COUNT),
        .TEXT_BITS  (TEXT_BITS)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .command     (command),
        .position    (position),
        .name_text   (name_text),
        .level_text  (level_text),
        .game_text   (game_text),
        .cmd         (cmd),
        .st          (st),
        .strobe      (strobe),
        .status      (status),
        .entry_count (entry_count),
        .slot        (slot),
        .out_name    (out_name),
        .out_level   (out_level),
        .out_game    (out_game),
        .last_of_run (last_of_run)
    );

endmodule

// ===== sv/alle_ctrl.sv =====
// Controller state machine for the array linked list engine.
module alle_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  alle_pkg::alle_stat_t st,
    output alle_pkg::alle_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_FREE   = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_ACT    = 3'd4;
    localparam logic [2:0] S_LIST   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       adding;

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign adding = (st.cmd == alle_pkg::CMD_ADD_FIRST) || (st.cmd == alle_pkg::CMD_ADD_AFTER)
                 || (st.cmd == alle_pkg::CMD_ADD_LAST);

    always_comb
    begin
        state_next = state_reg;
        cmd.op = alle_pkg::OP_NONE;
        cmd.rej_status = alle_pkg::ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op = alle_pkg::OP_LOAD;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (adding && st.full)
                begin
                    cmd.op = alle_pkg::OP_EMIT_REJ;
                    cmd.rej_status = alle_pkg::ST_FULL;
                    state_next = S_IDLE;
                end
                else if (((st.cmd == alle_pkg::CMD_ADD_AFTER) && !st.pos_ok)
                      || ((st.cmd == alle_pkg::CMD_DEL_AFTER)
                          && !(st.pos_ok && st.pos_has_next)))
                begin
                    cmd.op = alle_pkg::OP_EMIT_REJ;
                    cmd.rej_status = alle_pkg::ST_BAD;
                    state_next = S_IDLE;
                end
                else if (!adding && (st.cmd != alle_pkg::CMD_DEL_AFTER) && st.empty)
                begin
                    cmd.op = alle_pkg::OP_EMIT_REJ;
                    cmd.rej_status = alle_pkg::ST_EMPTY;
                    state_next = S_IDLE;
                end
                else
                begin
                    case (st.cmd)
                        alle_pkg::CMD_ADD_FIRST, alle_pkg::CMD_ADD_AFTER,
                        alle_pkg::CMD_ADD_LAST:
                        begin
                            state_next = S_FREE;
                        end
                        alle_pkg::CMD_DEL_FIRST, alle_pkg::CMD_DEL_AFTER,
                        alle_pkg::CMD_DEL_ALL:
                        begin
                            state_next = S_ACT;
                        end
                        alle_pkg::CMD_DEL_LAST:
                        begin
                            if (st.head_single)
                            begin
                                state_next = S_ACT;
                            end
                            else
                            begin
                                cmd.op = alle_pkg::OP_WALK_INIT;
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            cmd.op = alle_pkg::OP_WALK_INIT;
                            state_next = S_LIST;
                        end
                    endcase
                end
            end
            S_FREE:
            begin
                if (st.free_found)
                begin
                    if ((st.cmd == alle_pkg::CMD_ADD_LAST) && !st.empty)
                    begin
                        cmd.op = alle_pkg::OP_WALK_INIT;
                        state_next = S_WALK;
                    end
                    else
                    begin
                        state_next = S_ACT;
                    end
                end
                else
                begin
                    cmd.op = alle_pkg::OP_FREE_STEP;
                end
            end
            S_WALK:
            begin
                if (st.walk_done)
                begin
                    state_next = S_ACT;
                end
                else
                begin
                    cmd.op = alle_pkg::OP_WALK_STEP;
                end
            end
            S_ACT:
            begin
                state_next = S_IDLE;
                case (st.cmd)
                    alle_pkg::CMD_ADD_FIRST: cmd.op = alle_pkg::OP_INS_HEAD;
                    alle_pkg::CMD_ADD_AFTER: cmd.op = alle_pkg::OP_INS_AFTER;
                    alle_pkg::CMD_ADD_LAST:
                    begin
                        cmd.op = st.empty ? alle_pkg::OP_INS_HEAD : alle_pkg::OP_INS_TAIL;
                    end
                    alle_pkg::CMD_DEL_FIRST: cmd.op = alle_pkg::OP_DEL_HEAD;
                    alle_pkg::CMD_DEL_AFTER: cmd.op = alle_pkg::OP_DEL_AFTER;
                    alle_pkg::CMD_DEL_LAST:
                    begin
                        cmd.op = st.head_single ? alle_pkg::OP_DEL_HEAD
                                                : alle_pkg::OP_DEL_LAST;
                    end
                    default: cmd.op = alle_pkg::OP_CLEAR;
                endcase
            end
            S_LIST:
            begin
                cmd.op = alle_pkg::OP_LIST_STEP;
                if (st.list_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/alle_dp.sv =====
// Datapath of the array linked list engine: links, text store, count, result.
module alle_dp
#(
    parameter int SLOT_COUNT = 8,
    parameter int TEXT_BITS  = 64
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [alle_pkg::CMD_W-1:0]    command,
    input  logic [alle_pkg::POS_W-1:0]    position,
    input  logic [alle_pkg::DATA_W-1:0]   name_text,
    input  logic [alle_pkg::DATA_W-1:0]   level_text,
    input  logic [alle_pkg::DATA_W-1:0]   game_text,
    input  alle_pkg::alle_cmd_t           cmd,
    output alle_pkg::alle_stat_t          st,
    output logic                          strobe,
    output logic [alle_pkg::STAT_W-1:0]   status,
    output logic [alle_pkg::CNT_W-1:0]    entry_count,
    output logic [alle_pkg::POS_W-1:0]    slot,
    output logic [alle_pkg::DATA_W-1:0]   out_name,
    output logic [alle_pkg::DATA_W-1:0]   out_level,
    output logic [alle_pkg::DATA_W-1:0]   out_game,
    output logic                          last_of_run
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int LW = IW + 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [LW-1:0] END_MARK = LW'(SLOT_COUNT);

    logic [LW-1:0] link_reg [SLOT_COUNT];
    logic [LW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic [TEXT_BITS-1:0] name_mem [SLOT_COUNT];
    logic [TEXT_BITS-1:0] level_mem [SLOT_COUNT];
    logic [TEXT_BITS-1:0] game_mem [SLOT_COUNT];

    logic [alle_pkg::CMD_W-1:0] cmd_reg;
    logic [alle_pkg::POS_W-1:0] pos_reg;
    logic [TEXT_BITS-1:0] nt_reg, lt_reg, gt_reg;
    logic [IW-1:0] free_reg;
    logic [LW-1:0] walk_reg;
    logic [CW-1:0] k_reg;

    logic pos_in;
    logic [IW-1:0] pos_idx;
    logic [LW-1:0] walk_next_link;
    logic [IW-1:0] walk_idx;

    assign pos_in  = (32'(pos_reg) < SLOT_COUNT);
    assign pos_idx = IW'(pos_reg);
    assign walk_idx = walk_reg[IW-1:0];
    assign walk_next_link = link_reg[walk_idx];

    // a slot is in use when it is linked from somewhere or is the head
    logic [SLOT_COUNT-1:0] used_vec;
    always_comb
    begin
        used_vec = '0;
        if (head_reg < END_MARK)
        begin
            used_vec[head_reg[IW-1:0]] = 1'b1;
        end
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (link_reg[i] < END_MARK)
            begin
                used_vec[link_reg[i][IW-1:0]] = 1'b1;
            end
        end
    end

    logic pos_live;
    assign pos_live = pos_in && used_vec[pos_idx];

    logic free_is;
    assign free_is = !used_vec[free_reg];

    always_comb
    begin
        st.cmd = cmd_reg;
        st.full = (32'(count_reg) >= SLOT_COUNT);
        st.empty = (count_reg == '0) || (head_reg >= END_MARK);
        st.pos_ok = pos_live;
        st.pos_has_next = (link_reg[pos_idx] < END_MARK);
        st.free_found = free_is;
        st.head_single = (link_reg[head_reg[IW-1:0]] >= END_MARK);
        if (cmd_reg == alle_pkg::CMD_DEL_LAST)
        begin
            st.walk_done = (walk_next_link >= END_MARK)
                        || (link_reg[walk_next_link[IW-1:0]] >= END_MARK);
        end
        else
        begin
            st.walk_done = (walk_next_link >= END_MARK);
        end
        st.list_last = (walk_next_link >= END_MARK) || (32'(k_reg) + 1 >= SLOT_COUNT);
    end

    logic [IW-1:0] victim;
    always_comb
    begin
        victim = walk_next_link[IW-1:0];
        if (cmd.op == alle_pkg::OP_DEL_AFTER)
        begin
            victim = link_reg[pos_idx][IW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == alle_pkg::OP_LOAD)
        begin
            cmd_reg <= command;
            pos_reg <= position;
            nt_reg <= name_text[TEXT_BITS-1:0];
            lt_reg <= level_text[TEXT_BITS-1:0];
            gt_reg <= game_text[TEXT_BITS-1:0];
        end
        if ((cmd.op == alle_pkg::OP_INS_HEAD) || (cmd.op == alle_pkg::OP_INS_AFTER)
            || (cmd.op == alle_pkg::OP_INS_TAIL))
        begin
            name_mem[free_reg] <= nt_reg;
            level_mem[free_reg] <= lt_reg;
            game_mem[free_reg] <= gt_reg;
        end
        out_name <= '0;
        out_level <= '0;
        out_game <= '0;
        if (cmd.op == alle_pkg::OP_LIST_STEP)
        begin
            out_name <= alle_pkg::DATA_W'(name_mem[walk_idx]);
            out_level <= alle_pkg::DATA_W'(level_mem[walk_idx]);
            out_game <= alle_pkg::DATA_W'(game_mem[walk_idx]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= END_MARK;
            count_reg <= '0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                link_reg[i] <= END_MARK;
            end
            free_reg <= '0;
            walk_reg <= '0;
            k_reg <= '0;
            strobe <= 1'b0;
            status <= '0;
            entry_count <= '0;
            slot <= '0;
            last_of_run <= 1'b0;
        end
        else
        begin
            strobe <= 1'b0;
            last_of_run <= 1'b0;
            case (cmd.op)
                alle_pkg::OP_LOAD:
                begin
                    free_reg <= '0;
                    k_reg <= '0;
                end
                alle_pkg::OP_FREE_STEP:
                begin
                    free_reg <= free_reg + 1'b1;
                end
                alle_pkg::OP_WALK_INIT:
                begin
                    walk_reg <= head_reg;
                end
                alle_pkg::OP_WALK_STEP:
                begin
                    walk_reg <= walk_next_link;
                end
                alle_pkg::OP_INS_HEAD:
                begin
                    link_reg[free_reg] <= head_reg;
                    head_reg <= {1'b0, free_reg};
                end
                alle_pkg::OP_INS_AFTER:
                begin
                    link_reg[free_reg] <= link_reg[pos_idx];
                    link_reg[pos_idx] <= {1'b0, free_reg};
                end
                alle_pkg::OP_INS_TAIL:
                begin
                    link_reg[free_reg] <= END_MARK;
                    link_reg[walk_idx] <= {1'b0, free_reg};
                end
                alle_pkg::OP_DEL_HEAD:
                begin
                    head_reg <= link_reg[head_reg[IW-1:0]];
                    link_reg[head_reg[IW-1:0]] <= END_MARK;
                end
                alle_pkg::OP_DEL_AFTER:
                begin
                    link_reg[pos_idx] <= link_reg[victim];
                    link_reg[victim] <= END_MARK;
                end
                alle_pkg::OP_DEL_LAST:
                begin
                    link_reg[walk_idx] <= link_reg[victim];
                    link_reg[victim] <= END_MARK;
                end
                alle_pkg::OP_CLEAR:
                begin
                    head_reg <= END_MARK;
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        link_reg[i] <= END_MARK;
                    end
                end
                alle_pkg::OP_LIST_STEP:
                begin
                    walk_reg <= walk_next_link;
                    k_reg <= k_reg + 1'b1;
                end
                default:
                begin
                end
            endcase

            case (cmd.op)
                alle_pkg::OP_EMIT_REJ:
                begin
                    strobe <= 1'b1;
                    last_of_run <= 1'b1;
                    status <= cmd.rej_status;
                    slot <= '0;
                    entry_count <= alle_pkg::CNT_W'(count_reg);
                end
                alle_pkg::OP_INS_HEAD, alle_pkg::OP_INS_AFTER, alle_pkg::OP_INS_TAIL:
                begin
                    count_reg <= count_reg + 1'b1;
                    strobe <= 1'b1;
                    last_of_run <= 1'b1;
                    status <= alle_pkg::ST_OK;
                    slot <= alle_pkg::POS_W'(free_reg);
                    entry_count <= alle_pkg::CNT_W'(count_reg + 1'b1);
                end
                alle_pkg::OP_DEL_HEAD:
                begin
                    count_reg <= count_reg - 1'b1;
                    strobe <= 1'b1;
                    last_of_run <= 1'b1;
                    status <= alle_pkg::ST_OK;
                    slot <= alle_pkg::POS_W'(head_reg[IW-1:0]);
                    entry_count <= alle_pkg::CNT_W'(count_reg - 1'b1);
                end
                alle_pkg::OP_DEL_AFTER, alle_pkg::OP_DEL_LAST:
                begin
                    count_reg <= count_reg - 1'b1;
                    strobe <= 1'b1;
                    last_of_run <= 1'b1;
                    status <= alle_pkg::ST_OK;
                    slot <= alle_pkg::POS_W'(victim);
                    entry_count <= alle_pkg::CNT_W'(count_reg - 1'b1);
                end
                alle_pkg::OP_CLEAR:
                begin
                    count_reg <= '0;
                    strobe <= 1'b1;
                    last_of_run <= 1'b1;
                    status <= alle_pkg::ST_OK;
                    slot <= '0;
                    entry_count <= '0;
                end
                alle_pkg::OP_LIST_STEP:
                begin
                    strobe <= 1'b1;
                    last_of_run <= st.list_last;
                    status <= alle_pkg::ST_OK;
                    slot <= alle_pkg::POS_W'(walk_idx);
                    entry_count <= alle_pkg::CNT_W'(count_reg);
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule
